// ===== src/midpoint_circle_rasterizer_macros.svh =====
// Assertion macros for the midpoint circle rasterizer.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_MACROS_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_MACROS_SVH
`ifndef ASSERT_OFF
`define MCR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MCR_ASSERT(label, ante, cons, msg)
`define MCR_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/mcr_pkg.sv =====
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies.
`default_nettype none
package mcr_pkg;
  localparam int COORD_BITS       = 12;
  localparam int RADIUS_BITS      = 10;
  localparam int XY_BITS          = RADIUS_BITS + 1;
  localparam int DEC_BITS         = RADIUS_BITS + 4;
  localparam int PIX_BITS         = COORD_BITS + 1;
  localparam int SUM_BITS         = (COORD_BITS + 1 > XY_BITS + 1) ? COORD_BITS + 1
                                                                   : XY_BITS + 1;
  localparam int PIXELS_PER_POINT = 8;
  localparam int PHASE_BITS       = $clog2(PIXELS_PER_POINT);
  localparam int QDEPTH           = 2;
  localparam int QPTR_BITS        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_BITS        = $clog2(QDEPTH + 1);

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam int INC_STEP = 3;
  localparam int INC_DIAG = 5;

  localparam logic [PHASE_BITS-1:0] LAST_PHASE = PHASE_BITS'(PIXELS_PER_POINT - 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [RADIUS_BITS-1:0] radius_t;
  typedef logic signed [XY_BITS-1:0]    xy_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;
  typedef logic signed [PIX_BITS-1:0]   pix_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    xy_t    x;
    xy_t    y;
    logic   done;
  } job_t;
endpackage
`default_nettype wire

// ===== src/mcr_in_if.sv =====
// Input channel interface: valid/ready plus circle command payload.
// Depends on mcr_pkg.
`default_nettype none
interface mcr_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  mcr_pkg::coord_t    center_x;
  mcr_pkg::coord_t    center_y;
  mcr_pkg::radius_t   radius;
  modport source (output valid, opcode, center_x, center_y, radius, input ready);
  modport sink   (input valid, opcode, center_x, center_y, radius, output ready);
endinterface
`default_nettype wire

// ===== src/mcr_out_if.sv =====
// Result channel interface: valid/ready plus one pixel per transfer.
// Depends on mcr_pkg.
`default_nettype none
interface mcr_out_if;
  logic          valid;
  logic          ready;
  mcr_pkg::pix_t pixel_x;
  mcr_pkg::pix_t pixel_y;
  logic          last_of_step;
  logic          circle_done;
  modport source (output valid, pixel_x, pixel_y, last_of_step, circle_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_of_step, circle_done, output ready);
endinterface
`default_nettype wire

// ===== src/mcr_front.sv =====
// Front end: takes commands, holds the octant point and decision value,
// and queues one job per productive step. Depends on mcr_pkg.
`default_nettype none
module mcr_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             opcode,
  input  wire mcr_pkg::coord_t  center_x,
  input  wire mcr_pkg::coord_t  center_y,
  input  wire mcr_pkg::radius_t radius,
  input  wire logic             q_full,
  output logic                  q_push,
  output mcr_pkg::job_t         q_job
);
  mcr_pkg::xy_t    cur_x_r, cur_x_nxt;
  mcr_pkg::xy_t    cur_y_r, cur_y_nxt;
  mcr_pkg::dec_t   dec_r, dec_nxt;
  mcr_pkg::coord_t cx_r, cx_nxt;
  mcr_pkg::coord_t cy_r, cy_nxt;
  logic            busy_r, busy_nxt;

  logic            accept;
  logic            live;
  mcr_pkg::xy_t    step_x, step_y;
  mcr_pkg::dec_t   dx, dy, inc_step, inc_diag;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign live     = busy_r && !(cur_x_r > cur_y_r);

  always_comb begin
    dx       = mcr_pkg::DEC_BITS'(cur_x_r);
    dy       = mcr_pkg::DEC_BITS'(cur_y_r);
    inc_step = (dx <<< 1) + mcr_pkg::DEC_BITS'(mcr_pkg::INC_STEP);
    inc_diag = ((dx - dy) <<< 1) + mcr_pkg::DEC_BITS'(mcr_pkg::INC_DIAG);
    step_x   = cur_x_r + mcr_pkg::XY_BITS'(1);
    step_y   = (dec_r > 0) ? cur_y_r - mcr_pkg::XY_BITS'(1) : cur_y_r;
  end

  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    dec_nxt   = dec_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    busy_nxt  = busy_r;
    q_push    = 1'b0;
    q_job.cx   = cx_r;
    q_job.cy   = cy_r;
    q_job.x    = cur_x_r;
    q_job.y    = cur_y_r;
    q_job.done = step_x > step_y;
    if (accept) begin
      if (opcode == mcr_pkg::OP_START) begin
        cx_nxt    = center_x;
        cy_nxt    = center_y;
        cur_x_nxt = '0;
        cur_y_nxt = signed'(mcr_pkg::XY_BITS'(radius));
        dec_nxt   = mcr_pkg::DEC_BITS'(1) - signed'(mcr_pkg::DEC_BITS'(radius));
        busy_nxt  = 1'b1;
      end else if (live) begin
        q_push    = 1'b1;
        cur_x_nxt = step_x;
        cur_y_nxt = step_y;
        dec_nxt   = (dec_r > 0) ? dec_r + inc_diag : dec_r + inc_step;
        busy_nxt  = !(step_x > step_y);
      end else begin
        busy_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
      dec_r   <= '0;
      cx_r    <= '0;
      cy_r    <= '0;
      busy_r  <= 1'b0;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      dec_r   <= dec_nxt;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      busy_r  <= busy_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== src/mcr_queue.sv =====
// Short job queue between front and back end.
// Depends on mcr_pkg and the assertion macros.
`default_nettype none
`include "midpoint_circle_rasterizer_macros.svh"
module mcr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire mcr_pkg::job_t  push_job,
  output logic                full,
  output logic                pop_valid,
  input  wire logic           pop,
  output mcr_pkg::job_t       pop_job
);
  mcr_pkg::job_t                  mem [mcr_pkg::QDEPTH];
  logic [mcr_pkg::QPTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [mcr_pkg::QPTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [mcr_pkg::QCNT_BITS-1:0]  count_r, count_nxt;

  localparam logic [mcr_pkg::QPTR_BITS-1:0] PTR_LAST = mcr_pkg::QPTR_BITS'(mcr_pkg::QDEPTH - 1);
  localparam logic [mcr_pkg::QCNT_BITS-1:0] CNT_FULL = mcr_pkg::QCNT_BITS'(mcr_pkg::QDEPTH);

  assign full      = count_r == CNT_FULL;
  assign pop_valid = count_r != '0;
  assign pop_job   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `MCR_ASSERT(a_no_overflow, push, !full, "queue push while full")
  `MCR_ASSERT(a_no_underflow, pop, pop_valid, "queue pop while empty")
  `MCR_ASSERT(a_count_bound, 1'b1, count_r <= CNT_FULL, "queue count beyond depth")
endmodule
`default_nettype wire

// ===== src/mcr_back.sv =====
// Back end: expands one queued job into eight mirrored pixels, one per cycle unless out_ready stalls,
// through a registered output stage. Depends on mcr_pkg and the assertion macros.
`default_nettype none
`include "midpoint_circle_rasterizer_macros.svh"
module mcr_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          pop_valid,
  input  wire mcr_pkg::job_t pop_job,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mcr_pkg::pix_t      out_pixel_x,
  output mcr_pkg::pix_t      out_pixel_y,
  output logic               out_last,
  output logic               out_done
);
  mcr_pkg::job_t                  job_r, job_nxt;
  logic                           active_r, active_nxt;
  logic [mcr_pkg::PHASE_BITS-1:0] phase_r, phase_nxt;
  logic                           out_valid_r, out_valid_nxt;
  mcr_pkg::pix_t                  px_r, px_nxt;
  mcr_pkg::pix_t                  py_r, py_nxt;
  logic                           last_r, last_nxt;
  logic                           done_r, done_nxt;

  logic          adv;
  logic          at_last;
  mcr_pkg::xy_t  a, b;
  mcr_pkg::sum_t sx, sy, da, db, sum_x, sum_y;

  assign adv     = active_r && (!out_valid_r || out_ready);
  assign at_last = phase_r == mcr_pkg::LAST_PHASE;
  assign pop     = pop_valid && (!active_r || (adv && at_last));

  always_comb begin
    a     = phase_r[2] ? job_r.y : job_r.x;
    b     = phase_r[2] ? job_r.x : job_r.y;
    sx    = mcr_pkg::SUM_BITS'(job_r.cx);
    sy    = mcr_pkg::SUM_BITS'(job_r.cy);
    da    = mcr_pkg::SUM_BITS'(a);
    db    = mcr_pkg::SUM_BITS'(b);
    sum_x = phase_r[0] ? sx - da : sx + da;
    sum_y = phase_r[1] ? sy - db : sy + db;
  end

  always_comb begin
    job_nxt       = job_r;
    active_nxt    = active_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    last_nxt      = last_r;
    done_nxt      = done_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      px_nxt        = mcr_pkg::PIX_BITS'(sum_x);
      py_nxt        = mcr_pkg::PIX_BITS'(sum_y);
      last_nxt      = at_last;
      done_nxt      = at_last && job_r.done;
      phase_nxt     = phase_r + 1'b1;
      if (at_last) begin
        active_nxt = pop;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      job_nxt    = pop_job;
      active_nxt = 1'b1;
      phase_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      done_r      <= done_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel_x = px_r;
  assign out_pixel_y = py_r;
  assign out_last    = last_r;
  assign out_done    = done_r;

  `MCR_ASSERT(a_done_on_last, out_valid_r && done_r, last_r, "done flag off the last pixel")
  `MCR_ASSERT_NEXT(a_pop_starts, pop, active_r && phase_r == '0, "job load did not restart")
  `MCR_ASSERT_NEXT(a_job_holds, adv && !at_last, active_r, "job dropped mid-point")
endmodule
`default_nettype wire

// ===== src/midpoint_circle_rasterizer.sv =====
// Midpoint circle rasterizer: a start transfer loads centre and radius, each step
// transfer on an active circle yields the eight mirrored pixels of one octant point.
// A step's pixels pass through the job queue, the back end's job register and its output register to out_ch.
// One pixel per cycle while out_ch.ready holds; the next job is taken as the last pixel of a step is registered.
// Reset (rst_n low, synchronous): no circle active, job queue empty, output idle.
`default_nettype none
module midpoint_circle_rasterizer (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mcr_in_if.sink      in_ch,
  mcr_out_if.source   out_ch
);
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_pop_valid;
  mcr_pkg::job_t q_push_job;
  mcr_pkg::job_t q_pop_job;

  mcr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .opcode   (in_ch.opcode),
    .center_x (in_ch.center_x),
    .center_y (in_ch.center_y),
    .radius   (in_ch.radius),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_push_job)
  );

  mcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_push_job),
    .full      (q_full),
    .pop_valid (q_pop_valid),
    .pop       (q_pop),
    .pop_job   (q_pop_job)
  );

  mcr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (q_pop_valid),
    .pop_job     (q_pop_job),
    .pop         (q_pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_pixel_x (out_ch.pixel_x),
    .out_pixel_y (out_ch.pixel_y),
    .out_last    (out_ch.last_of_step),
    .out_done    (out_ch.circle_done)
  );
endmodule
`default_nettype wire

// ===== verif/midpoint_circle_rasterizer_tb.sv =====
// Self-checking bench for midpoint_circle_rasterizer: a directed command table, then
// random circles, each pixel transfer checked against the tracer or a table centre.
// Depends on mcr_pkg, mcr_in_if, mcr_out_if and the rasterizer RTL.
module midpoint_circle_rasterizer_tb;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_CENTRE} chk_t;

  typedef struct packed {
    logic             op;
    mcr_pkg::coord_t  cx;
    mcr_pkg::coord_t  cy;
    mcr_pkg::radius_t r;
    chk_t             chk;
  } cmd_row_t;

  typedef struct packed {
    mcr_pkg::pix_t x;
    mcr_pkg::pix_t y;
    logic          last;
    logic          done;
  } pixel_t;

  localparam int N_PLAN   = 24;
  localparam int N_RANDOM = 420;

  logic clk;
  logic rst_n;

  mcr_in_if  in_ch();
  mcr_out_if out_ch();

  midpoint_circle_rasterizer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // tracer state
  mcr_pkg::xy_t    pt_x;
  mcr_pkg::xy_t    pt_y;
  mcr_pkg::dec_t   pt_dec;
  mcr_pkg::coord_t held_cx;
  mcr_pkg::coord_t held_cy;
  logic            circle_on = 1'b0;
  pixel_t          octant_px [mcr_pkg::PIXELS_PER_POINT];

  pixel_t pix_q [$];
  pixel_t want_px;

  int send_idle = 14;
  int recv_idle = 46;
  int errors    = 0;
  int n_items   = 0;
  int n_circles = 0;
  int n_pixels  = 0;

  // step rows of type CHK_CENTRE carry the expected centre in cx/cy
  cmd_row_t plan [N_PLAN] = '{
    '{mcr_pkg::OP_STEP,      0,     0,    0, CHK_NONE},
    '{mcr_pkg::OP_STEP,  -2048,  2047, 1023, CHK_NONE},
    '{mcr_pkg::OP_START,  2047, -2048,    0, CHK_MODEL},
    '{mcr_pkg::OP_STEP,   2047, -2048,    0, CHK_CENTRE},
    '{mcr_pkg::OP_STEP,      0,     0,    0, CHK_NONE},
    '{mcr_pkg::OP_START, -2048, -2048,    0, CHK_MODEL},
    '{mcr_pkg::OP_STEP,  -2048, -2048,    0, CHK_CENTRE},
    '{mcr_pkg::OP_START, -2048,  2047, 1023, CHK_MODEL},
    '{mcr_pkg::OP_STEP,      1,     2,    3, CHK_MODEL},
    '{mcr_pkg::OP_STEP,   2047,  2047, 1023, CHK_MODEL},
    '{mcr_pkg::OP_STEP,  -2048, -2048,    0, CHK_MODEL},
    '{mcr_pkg::OP_START,  2047,  2047, 1023, CHK_MODEL},
    '{mcr_pkg::OP_STEP,      0,     0,    0, CHK_MODEL},
    '{mcr_pkg::OP_STEP,      0,     0,    0, CHK_MODEL},
    '{mcr_pkg::OP_START,     0,     0,    1, CHK_MODEL},
    '{mcr_pkg::OP_STEP,      0,     0,    0, CHK_MODEL},
    '{mcr_pkg::OP_STEP,      0,     0,    0, CHK_MODEL},
    '{mcr_pkg::OP_STEP,      5,    -5,    7, CHK_NONE},
    '{mcr_pkg::OP_START,   100,  -100,    2, CHK_MODEL},
    '{mcr_pkg::OP_STEP,      0,     0,    0, CHK_MODEL},
    '{mcr_pkg::OP_STEP,      0,     0,    0, CHK_MODEL},
    '{mcr_pkg::OP_STEP,      0,     0,    0, CHK_NONE},
    '{mcr_pkg::OP_START,    -1,     1,  512, CHK_MODEL},
    '{mcr_pkg::OP_STEP,      0,     0,    0, CHK_MODEL}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("[midpoint_circle_rasterizer] ERROR");
    $finish;
  end

  function automatic int trace_octant(logic op, mcr_pkg::coord_t cx, mcr_pkg::coord_t cy,
                                      mcr_pkg::radius_t r);
    mcr_pkg::xy_t  ox;
    mcr_pkg::xy_t  oy;
    mcr_pkg::pix_t pcx;
    mcr_pkg::pix_t pcy;
    mcr_pkg::pix_t sx;
    mcr_pkg::pix_t sy;
    logic          fin;
    if (op == mcr_pkg::OP_START) begin
      held_cx   = cx;
      held_cy   = cy;
      pt_x      = '0;
      pt_y      = mcr_pkg::xy_t'(r);
      pt_dec    = mcr_pkg::dec_t'(1) - mcr_pkg::dec_t'(r);
      circle_on = 1'b1;
      return 0;
    end
    if (!circle_on || pt_x > pt_y) begin
      circle_on = 1'b0;
      return 0;
    end
    ox = pt_x;
    oy = pt_y;
    if (pt_dec <= 0) begin
      pt_dec = mcr_pkg::dec_t'(pt_dec + 2 * ox + 3);
    end else begin
      pt_dec = mcr_pkg::dec_t'(pt_dec + 2 * (ox - oy) + 5);
      pt_y   = mcr_pkg::xy_t'(oy - 1);
    end
    pt_x = mcr_pkg::xy_t'(ox + 1);
    fin  = (pt_x > pt_y);
    if (fin) circle_on = 1'b0;
    pcx = mcr_pkg::pix_t'(held_cx);
    pcy = mcr_pkg::pix_t'(held_cy);
    sx  = mcr_pkg::pix_t'(ox);
    sy  = mcr_pkg::pix_t'(oy);
    octant_px[0] = '{pcx + sx, pcy + sy, 1'b0, 1'b0};
    octant_px[1] = '{pcx - sx, pcy + sy, 1'b0, 1'b0};
    octant_px[2] = '{pcx + sx, pcy - sy, 1'b0, 1'b0};
    octant_px[3] = '{pcx - sx, pcy - sy, 1'b0, 1'b0};
    octant_px[4] = '{pcx + sy, pcy + sx, 1'b0, 1'b0};
    octant_px[5] = '{pcx - sy, pcy + sx, 1'b0, 1'b0};
    octant_px[6] = '{pcx + sy, pcy - sx, 1'b0, 1'b0};
    octant_px[7] = '{pcx - sy, pcy - sx, 1'b1, fin};
    return mcr_pkg::PIXELS_PER_POINT;
  endfunction

  task automatic flag(string msg);
    if (errors < 40) $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic send_cmd(logic op, mcr_pkg::coord_t cx, mcr_pkg::coord_t cy,
                          mcr_pkg::radius_t r, chk_t chk);
    int gap;
    int got;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.center_x <= cx;
    in_ch.center_y <= cy;
    in_ch.radius   <= r;
    do @(posedge clk); while (!in_ch.ready);
    got = trace_octant(op, cx, cy, r);
    if (chk == CHK_MODEL) begin
      for (int i = 0; i < got; i++) pix_q.push_back(octant_px[i]);
    end else if (chk == CHK_CENTRE) begin
      for (int i = 0; i < mcr_pkg::PIXELS_PER_POINT; i++)
        pix_q.push_back('{mcr_pkg::pix_t'(cx), mcr_pkg::pix_t'(cy), i == 7, i == 7});
    end
    if (op == mcr_pkg::OP_START || got > 0) n_items++;
    if (op == mcr_pkg::OP_START) n_circles++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pix_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_step();
    send_cmd(mcr_pkg::OP_STEP, mcr_pkg::coord_t'($urandom), mcr_pkg::coord_t'($urandom),
             mcr_pkg::radius_t'($urandom), CHK_MODEL);
  endtask

  task automatic random_circle();
    mcr_pkg::radius_t r;
    int               u;
    int               cap;
    u = $urandom_range(99);
    if (u < 70) r = mcr_pkg::radius_t'($urandom_range(15));
    else if (u < 95) r = mcr_pkg::radius_t'($urandom_range(90, 16));
    else r = mcr_pkg::radius_t'($urandom_range(1023, 91));
    send_cmd(mcr_pkg::OP_START, mcr_pkg::coord_t'($urandom), mcr_pkg::coord_t'($urandom), r,
             CHK_MODEL);
    cap = ($urandom_range(99) < 15) ? $urandom_range(6) : 80;
    while (circle_on && cap > 0) begin
      random_step();
      cap--;
    end
    if (!circle_on) begin
      repeat ($urandom_range(2)) random_step();
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_pixels++;
      if (pix_q.size() == 0) begin
        flag($sformatf("unexpected pixel (%0d,%0d)", out_ch.pixel_x, out_ch.pixel_y));
      end else begin
        want_px = pix_q.pop_front();
        if (out_ch.pixel_x !== want_px.x)
          flag($sformatf("pixel_x %0d, want %0d", out_ch.pixel_x, want_px.x));
        if (out_ch.pixel_y !== want_px.y)
          flag($sformatf("pixel_y %0d, want %0d", out_ch.pixel_y, want_px.y));
        if (out_ch.last_of_step !== want_px.last)
          flag($sformatf("last_of_step %b, want %b", out_ch.last_of_step, want_px.last));
        if (out_ch.circle_done !== want_px.done)
          flag($sformatf("circle_done %b, want %b", out_ch.circle_done, want_px.done));
      end
    end
  end

  initial begin
    int base;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= mcr_pkg::OP_START;
    in_ch.center_x <= '0;
    in_ch.center_y <= '0;
    in_ch.radius   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_PLAN; i++)
      send_cmd(plan[i].op, plan[i].cx, plan[i].cy, plan[i].r, plan[i].chk);
    settle();

    base = n_items;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 14;
          recv_idle = 46;
        end
        1: begin
          send_idle = 46;
          recv_idle = 14;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      while (n_items < base + (ph + 1) * N_RANDOM / 3) begin
        if ($urandom_range(99) < 5) random_step();
        random_circle();
      end
      settle();
    end

    in_ch.valid <= 1'b0;
    settle();
    $display("covered %0d commands over %0d circles, %0d pixel transfers checked",
             n_items, n_circles, n_pixels);
    if (errors == 0) begin
      $display("[midpoint_circle_rasterizer] OK");
    end else begin
      $display("[midpoint_circle_rasterizer] ERROR");
    end
    $finish;
  end
endmodule
